// File: rtl/sha1md_pkg.sv
// ----------------------------------------------------------------------------
// sha1md_pkg
// Shared constants and controller/datapath interface types for the
// streaming SHA-1 digest core.
// ----------------------------------------------------------------------------
package sha1md_pkg;

  localparam int unsigned NumHashWords  = 5;
  localparam int unsigned NumSchedWords = 16;
  localparam int unsigned LenWidth      = 61;
  localparam int unsigned RoundWidth    = 7;
  localparam int unsigned WordIdxWidth  = 3;
  localparam int unsigned CfgAddrWidth  = 3;

  localparam logic [RoundWidth-1:0]   LastRound   = 7'd79;
  localparam logic [WordIdxWidth-1:0] LastWordIdx = 3'd4;

  localparam logic [CfgAddrWidth-1:0] CfgPriorLen = 3'd5;

  localparam logic [NumHashWords-1:0][31:0] InitVec = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PadByte = 8'h80;

  typedef struct packed {
    logic                    take_item;
    logic                    pad;
    logic                    len_block;
    logic                    load_vars;
    logic                    round;
    logic                    add_hash;
    logic                    reload;
    logic [RoundWidth-1:0]   round_idx;
    logic [WordIdxWidth-1:0] word_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic block_done;
    logic two_blocks;
  } dp_status_t;

endpackage

// File: rtl/sha1md_ctrl.sv
// ----------------------------------------------------------------------------
// sha1md_ctrl
// Sequencer: byte intake, compression round counting, padding blocks and
// digest word output.
// ----------------------------------------------------------------------------
module sha1md_ctrl import sha1md_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    end_of_message_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [WordIdxWidth-1:0] word_index_o,
  output logic                    last_word_o,
  input  dp_status_t              status_i,
  output dp_cmd_t                 cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INIT  = 3'd1;
  localparam logic [2:0] S_ROUND = 3'd2;
  localparam logic [2:0] S_FINAL = 3'd3;
  localparam logic [2:0] S_PAD   = 3'd4;
  localparam logic [2:0] S_LEN   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  localparam logic [1:0] PH_DATA = 2'd0;
  localparam logic [1:0] PH_PAD1 = 2'd1;
  localparam logic [1:0] PH_LAST = 2'd2;

  logic [2:0]              state_q, state_d;
  logic [1:0]              phase_q, phase_d;
  logic                    eom_q, eom_d;
  logic [RoundWidth-1:0]   round_q, round_d;
  logic [WordIdxWidth-1:0] word_q, word_d;

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = (state_q == S_OUT);
  assign word_index_o = word_q;
  assign last_word_o  = (word_q == LastWordIdx);

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    eom_d   = eom_q;
    round_d = round_q;
    word_d  = word_q;
    cmd_o   = '0;
    cmd_o.round_idx = round_q;
    cmd_o.word_idx  = word_q;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.take_item = in_valid_i;
        if (in_valid_i) begin
          eom_d = end_of_message_i;
          if (status_i.block_done) begin
            phase_d = PH_DATA;
            state_d = S_INIT;
          end else if (end_of_message_i) begin
            state_d = S_PAD;
          end
        end
      end
      S_INIT: begin
        cmd_o.load_vars = 1'b1;
        round_d = '0;
        state_d = S_ROUND;
      end
      S_ROUND: begin
        cmd_o.round = 1'b1;
        round_d = round_q + 1'b1;
        if (round_q == LastRound) begin
          state_d = S_FINAL;
        end
      end
      S_FINAL: begin
        cmd_o.add_hash = 1'b1;
        case (phase_q)
          PH_DATA: state_d = eom_q ? S_PAD : S_IDLE;
          PH_PAD1: state_d = S_LEN;
          default: begin
            word_d  = '0;
            state_d = S_OUT;
          end
        endcase
      end
      S_PAD: begin
        cmd_o.pad = 1'b1;
        phase_d = status_i.two_blocks ? PH_PAD1 : PH_LAST;
        state_d = S_INIT;
      end
      S_LEN: begin
        cmd_o.len_block = 1'b1;
        phase_d = PH_LAST;
        state_d = S_INIT;
      end
      S_OUT: begin
        if (out_ready_i) begin
          word_d = word_q + 1'b1;
          if (word_q == LastWordIdx) begin
            cmd_o.reload = 1'b1;
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_DATA;
      eom_q   <= 1'b0;
      round_q <= '0;
      word_q  <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      eom_q   <= eom_d;
      round_q <= round_d;
      word_q  <= word_d;
    end
  end

endmodule

// File: rtl/sha1md_dp.sv
// ----------------------------------------------------------------------------
// sha1md_dp
// Datapath: configuration registers, message schedule shift line, round
// variables, hash state and length counter.
// ----------------------------------------------------------------------------
module sha1md_dp import sha1md_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgAddrWidth-1:0] cfg_addr_i,
  input  logic [LenWidth-1:0]     cfg_wdata_i,
  input  logic [7:0]              msg_byte_i,
  input  logic                    byte_present_i,
  input  dp_cmd_t                 cmd_i,
  output dp_status_t              status_o,
  output logic [31:0]             digest_word_o,
  output logic                    length_error_o
);

  logic [31:0]         init_q [NumHashWords];
  logic [LenWidth-1:0] prior_q;
  logic [31:0]         hash_q [NumHashWords];
  logic [31:0]         vars_q [NumHashWords];
  logic [31:0]         sched_q [NumSchedWords];
  logic [LenWidth-1:0] total_q;
  logic [5:0]          fill_q;
  logic                ovf_q;
  logic                open_q;

  logic        len_full;
  logic        byte_ok;
  logic [3:0]  widx;
  logic [7:0]  put_byte;
  logic [31:0] put_word;
  logic [31:0] cur_word;
  logic [31:0] len_hi;
  logic [31:0] len_lo;
  logic [31:0] xw;
  logic [31:0] wt;
  logic [31:0] fb;
  logic [31:0] kt;
  logic [31:0] tmp;

  assign len_full = (total_q == {LenWidth{1'b1}});
  assign byte_ok  = byte_present_i && !len_full;

  assign status_o.block_done = byte_ok && (fill_q == 6'd63);
  assign status_o.two_blocks = (fill_q >= 6'd56);

  assign widx     = fill_q[5:2];
  assign put_byte = cmd_i.pad ? PadByte : msg_byte_i;
  assign cur_word = sched_q[widx];

  always_comb begin
    case (fill_q[1:0])
      2'd0:    put_word = {put_byte, 24'd0};
      2'd1:    put_word = {cur_word[31:24], put_byte, 16'd0};
      2'd2:    put_word = {cur_word[31:16], put_byte, 8'd0};
      default: put_word = {cur_word[31:8], put_byte};
    endcase
  end

  assign len_hi = total_q[LenWidth-1:29];
  assign len_lo = {total_q[28:0], 3'd0};

  assign xw = sched_q[13] ^ sched_q[8] ^ sched_q[2] ^ sched_q[0];
  assign wt = (cmd_i.round_idx < 7'd16) ? sched_q[0] : {xw[30:0], xw[31]};

  always_comb begin
    if (cmd_i.round_idx < 7'd20) begin
      fb = (vars_q[1] & vars_q[2]) | (~vars_q[1] & vars_q[3]);
      kt = K0;
    end else if (cmd_i.round_idx < 7'd40) begin
      fb = vars_q[1] ^ vars_q[2] ^ vars_q[3];
      kt = K1;
    end else if (cmd_i.round_idx < 7'd60) begin
      fb = (vars_q[1] & vars_q[2]) | (vars_q[1] & vars_q[3]) | (vars_q[2] & vars_q[3]);
      kt = K2;
    end else begin
      fb = vars_q[1] ^ vars_q[2] ^ vars_q[3];
      kt = K3;
    end
  end

  assign tmp = {vars_q[0][26:0], vars_q[0][31:27]} + fb + vars_q[4] + wt + kt;

  assign digest_word_o  = hash_q[cmd_i.word_idx];
  assign length_error_o = ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumHashWords; i++) begin
        init_q[i] <= InitVec[i];
        hash_q[i] <= InitVec[i];
      end
      prior_q <= '0;
      total_q <= '0;
      fill_q  <= '0;
      ovf_q   <= 1'b0;
      open_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_addr_i < CfgPriorLen) begin
          init_q[cfg_addr_i] <= cfg_wdata_i[31:0];
          if (!open_q) begin
            hash_q[cfg_addr_i] <= cfg_wdata_i[31:0];
          end
        end else if (cfg_addr_i == CfgPriorLen) begin
          prior_q <= cfg_wdata_i;
          if (!open_q) begin
            total_q <= cfg_wdata_i;
          end
        end
      end
      if (cmd_i.take_item && byte_present_i) begin
        open_q <= 1'b1;
        if (len_full) begin
          ovf_q <= 1'b1;
        end else begin
          total_q <= total_q + 1'b1;
          fill_q  <= fill_q + 1'b1;
        end
      end
      if (cmd_i.add_hash) begin
        for (int i = 0; i < NumHashWords; i++) begin
          hash_q[i] <= hash_q[i] + vars_q[i];
        end
      end
      if (cmd_i.reload) begin
        for (int i = 0; i < NumHashWords; i++) begin
          hash_q[i] <= init_q[i];
        end
        total_q <= prior_q;
        fill_q  <= '0;
        ovf_q   <= 1'b0;
        open_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item && byte_ok) begin
      sched_q[widx] <= put_word;
    end
    if (cmd_i.pad) begin
      for (int i = 0; i < NumSchedWords; i++) begin
        if (4'(i) > widx) begin
          sched_q[i] <= '0;
        end
      end
      sched_q[widx] <= put_word;
      if (!status_o.two_blocks) begin
        sched_q[14] <= len_hi;
        sched_q[15] <= len_lo;
      end
    end
    if (cmd_i.len_block) begin
      for (int i = 0; i < NumSchedWords - 2; i++) begin
        sched_q[i] <= '0;
      end
      sched_q[14] <= len_hi;
      sched_q[15] <= len_lo;
    end
    if (cmd_i.load_vars) begin
      for (int i = 0; i < NumHashWords; i++) begin
        vars_q[i] <= hash_q[i];
      end
    end
    if (cmd_i.round) begin
      for (int i = 0; i < NumSchedWords - 1; i++) begin
        sched_q[i] <= sched_q[i+1];
      end
      sched_q[15] <= wt;
      vars_q[0] <= tmp;
      vars_q[1] <= vars_q[0];
      vars_q[2] <= {vars_q[1][1:0], vars_q[1][31:2]};
      vars_q[3] <= vars_q[2];
      vars_q[4] <= vars_q[3];
    end
  end

endmodule

// File: rtl/sha1_message_digest_core.sv
// ----------------------------------------------------------------------------
// sha1_message_digest_core
// Streaming SHA-1 with configurable initial state and prior length.
// A byte that fills a 64-byte block starts a compression (load, 80 rounds at
// one per cycle, hash add). End of message adds padding and compression (a
// second pad block and compression when the padding does not fit), then five
// digest words, one per accepted output cycle.
// Reset (async, active low) loads the standard initial words and zero length.
// ----------------------------------------------------------------------------
module sha1_message_digest_core import sha1md_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgAddrWidth-1:0] cfg_addr_i,
  input  logic [LenWidth-1:0]     cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [7:0]              msg_byte_i,
  input  logic                    byte_present_i,
  input  logic                    end_of_message_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [31:0]             digest_word_o,
  output logic [WordIdxWidth-1:0] word_index_o,
  output logic                    last_word_o,
  output logic                    length_error_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  sha1md_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .end_of_message_i (end_of_message_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .word_index_o     (word_index_o),
    .last_word_o      (last_word_o),
    .status_i         (status),
    .cmd_o            (cmd)
  );

  sha1md_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .msg_byte_i     (msg_byte_i),
    .byte_present_i (byte_present_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .digest_word_o  (digest_word_o),
    .length_error_o (length_error_o)
  );

endmodule
